/* rtl/core/spq_pkg.sv */
package spq_pkg;

  // occupancy and capacity are 7-bit quantities
  localparam int CntW = 7;

  // result status codes
  localparam logic [1:0] StEnq   = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StDeq   = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // operation codes
  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  // configuration register index
  localparam logic RegCapacity = 1'b0;

  typedef struct packed {
    logic signed [31:0] elem;
    logic signed [15:0] prio;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic            enq;
    logic            deq;
    entry_t          new_entry;
    logic [15:0]     new_key;
    logic [CntW-1:0] count;
  } cell_ctrl_t;

  // order-preserving unsigned key of a signed priority
  function automatic logic [15:0] prio_key(input logic signed [15:0] p);
    prio_key = {~p[15], p[14:0]};
  endfunction

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell #(
  parameter int Idx = 0
) (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     left_i,
  input  logic                left_gt_i,
  input  spq_pkg::entry_t     right_i,
  output logic                gt_o,
  output spq_pkg::entry_t     q_o
);

  localparam bit Beyond = (Idx > (2 ** spq_pkg::CntW) - 1);
  localparam logic [spq_pkg::CntW-1:0] IdxC = spq_pkg::CntW'(Idx);

  spq_pkg::entry_t entry_q, entry_d;
  logic occupied;
  logic at_tail;

  assign occupied = !Beyond && (IdxC < ctrl_i.count);
  assign at_tail  = !Beyond && (IdxC == ctrl_i.count);
  // strictly greater priority than the incoming pair: this entry moves up
  assign gt_o = occupied && (spq_pkg::prio_key(entry_q.prio) > ctrl_i.new_key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o || at_tail) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Channel  | Direction | Handshake                         | Payload
// command  | in        | start & !busy                     | func_i, elem_in_i, prio_in_i
// result   | out       | done_o, one cycle, no backpressure| status_o, elem_out_o,
//          |           |                                   | prio_out_o, occupancy_o
// config   | in (APB)  | psel & penable & pwrite (pready=1)| paddr, pwdata
//
// Transactions never stall: the result strobe rises the cycle
// after the command is taken, and busy stays low, so a command may be issued
// every cycle. The limit is the parallel insert/shift across the cell row.
// Reset clears the count, the result strobe and sets capacity to 64; the cell
// contents are not reset (only entries below the count are ever read).
// The receiver cannot stall results.
module sorted_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic signed [31:0] elem_in_i,
  input  logic signed [15:0] prio_in_i,
  // result
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] elem_out_o,
  output logic signed [15:0] prio_out_o,
  output logic [6:0]         occupancy_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = spq_pkg::CntW;
  // largest count the 7-bit counter can reach given the cell row
  localparam int DCap = (DEPTH > (2 ** CW) - 1) ? (2 ** CW) - 1 : DEPTH;
  localparam logic [CW-1:0] DCapC = CW'(DCap);

  // ---------------------------------------------------------------------
  // Configuration: one register at byte address 0
  // ---------------------------------------------------------------------
  logic [CW-1:0] cap_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(64);
    end else if (cfg_wr && (paddr[2] == spq_pkg::RegCapacity)) begin
      cap_q <= pwdata[CW-1:0];
    end
  end

  assign prdata = (paddr[2] == spq_pkg::RegCapacity) ? {{(32-CW){1'b0}}, cap_q} : 32'd0;

  // ---------------------------------------------------------------------
  // Control: occupancy count and the decision for this transaction
  // ---------------------------------------------------------------------
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_eff;
  logic          accept, full, do_enq, do_deq;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign cap_eff = (cap_q > DCapC) ? DCapC : cap_q;
  assign full    = (count_q >= cap_eff);
  assign do_enq  = accept && (func_i == spq_pkg::FuncEnq) && !full;
  assign do_deq  = accept && (func_i == spq_pkg::FuncDeq) && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CW'(1);
    end else if (do_deq) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: cell 0 is the head, ascending priority toward the tail.
  // On enqueue every cell holding a strictly greater priority moves one
  // place up and the new pair lands in the gap; equal priorities stay
  // ahead, keeping arrival order. On dequeue every cell takes its right
  // neighbor.
  // ---------------------------------------------------------------------
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     cell_q [DEPTH];
  logic                cell_gt [DEPTH];

  assign ctrl.enq            = do_enq;
  assign ctrl.deq            = do_deq;
  assign ctrl.new_entry.elem = elem_in_i;
  assign ctrl.new_entry.prio = prio_in_i;
  assign ctrl.new_key        = spq_pkg::prio_key(prio_in_i);
  assign ctrl.count          = count_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_gt;
    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign left_gt = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end
    spq_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .left_i   (left_e),
      .left_gt_i(left_gt),
      .right_i  (right_e),
      .gt_o     (cell_gt[i]),
      .q_o      (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic              done_q;
  logic [1:0]        status_q, status_d;
  logic signed [31:0] elem_q, elem_d;
  logic signed [15:0] prio_q, prio_d;
  logic [CW-1:0]     occ_q;

  always_comb begin
    elem_d = '0;
    prio_d = '0;
    if (func_i == spq_pkg::FuncEnq) begin
      status_d = full ? spq_pkg::StFull : spq_pkg::StEnq;
    end else if (count_q == '0) begin
      status_d = spq_pkg::StEmpty;
    end else begin
      status_d = spq_pkg::StDeq;
      elem_d   = cell_q[0].elem;
      prio_d   = cell_q[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      elem_q   <= elem_d;
      prio_q   <= prio_d;
      occ_q    <= count_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign elem_out_o  = elem_q;
  assign prio_out_o  = prio_q;
  assign occupancy_o = occ_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DCapC)
    else $error("occupancy beyond cell row");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_deq |=> (count_q == $past(count_q) - CW'(1)))
    else $error("dequeue did not lower occupancy");

  a_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != spq_pkg::StDeq)) |-> (elem_out_o == 0 && prio_out_o == 0))
    else $error("payload not zero on non-dequeue result");

  a_occ_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o == count_q))
    else $error("reported occupancy differs from count");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |->
      (spq_pkg::prio_key(cell_q[0].prio) <= spq_pkg::prio_key(cell_q[1].prio)))
    else $error("head entries out of order");
`endif

endmodule
